>>> hdl/windowed_local_minimum_detector_defines.svh
// Assertion macros used by the checker file of the valley detector.
`ifndef WINDOWED_LOCAL_MINIMUM_DETECTOR_DEFINES_SVH
`define WINDOWED_LOCAL_MINIMUM_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WLMD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wlmd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WLMD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wlmd: next-cycle check failed");

`endif

>>> hdl/wlmd_pkg.sv
package wlmd_pkg;

   localparam int MARGIN     = 8;
   localparam int MAX_FRAMES = 65536;
   localparam int TAPS       = 2 * MARGIN;
   localparam int COUNT_W    = $clog2(MAX_FRAMES);

   typedef logic signed [15:0]  sample_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [15:0]         frame_type;

endpackage

>>> hdl/windowed_local_minimum_detector.sv
// A valley result is registered and offered in the cycle after the transfer of the sample
// that completes its window.
// Throughput: one sample per cycle, set by the single register stage behind the row of
// compare cells; an undrained result stalls the input only while the output is blocked.
// Reset clears the frame counter and the result valid flag; the sample row and result data are not cleared.
module windowed_local_minimum_detector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample_value
   input  logic        req_tlast,   // last_of_clip
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] valley_frame
);
   import wlmd_pkg::*;

   localparam count_type COUNT_MAX  = COUNT_W'(MAX_FRAMES - 1);
   localparam count_type COUNT_FULL = COUNT_W'(TAPS);

   sample_type          req_sample;
   sample_type          tap [TAPS];
   logic [TAPS-1:0]     less;
   sample_type          centre;
   logic                new_less;
   logic                accept;
   logic                valley;
   count_type           frame_ff;
   count_type           frame_in;
   count_type           centre_frame;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   frame_type           rsp_data_ff;
   frame_type           rsp_data_in;

   assign req_sample = sample_type'(req_tdata);
   assign centre     = tap[MARGIN-1];
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   for (genvar g = 0; g < TAPS; g++) begin : g_cell
      if (g == 0) begin : g_head
         wlmd_cell u_cell (
            .clock      (clock),
            .shift      (accept),
            .sample_in  (req_sample),
            .centre     (centre),
            .sample_out (tap[g]),
            .less_out   (less[g])
         );
      end else begin : g_body
         wlmd_cell u_cell (
            .clock      (clock),
            .shift      (accept),
            .sample_in  (tap[g-1]),
            .centre     (centre),
            .sample_out (tap[g]),
            .less_out   (less[g])
         );
      end
   end

   // The arriving sample is the newest neighbour and is compared directly.
   assign new_less     = req_sample < centre;
   assign valley       = (frame_ff >= COUNT_FULL) && !new_less && !(|less);
   assign centre_frame = frame_ff - COUNT_W'(MARGIN);
   assign rsp_data_in  = 16'(centre_frame);

   always_comb begin
      frame_in = frame_ff;
      if (accept) begin
         if (req_tlast) begin
            frame_in = '0;
         end else if (frame_ff != COUNT_MAX) begin
            frame_in = frame_ff + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = valley;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_ff     <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/wlmd_cell.sv
module wlmd_cell (
   input  logic                 clock,
   input  logic                 shift,
   input  wlmd_pkg::sample_type sample_in,
   input  wlmd_pkg::sample_type centre,
   output wlmd_pkg::sample_type sample_out,
   output logic                 less_out
);
   import wlmd_pkg::*;

   sample_type sample_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         sample_ff <= sample_in;
      end
   end

   assign sample_out = sample_ff;
   // The centre cell compares with itself and so never reports a smaller value.
   assign less_out   = sample_ff < centre;

endmodule

>>> hdl/wlmd_checker.sv
`include "windowed_local_minimum_detector_defines.svh"

module wlmd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A result held back by the sink keeps its frame number.
   `WLMD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Outside reset, the input is only refused while a result waits in the output register.
   `WLMD_ASSERT_SAME(a_stall_cause, clock, reset, !req_tready, rsp_tvalid || reset)

   // A new result always follows a sample transfer in the cycle before.
   `WLMD_ASSERT_SAME(a_rsp_source, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready))

   // Reset empties the output register.
   `WLMD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind windowed_local_minimum_detector wlmd_checker u_wlmd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
